// ===== rtl/prws_pkg.sv =====
// Shared field widths, codes and the task record layout of the ready/wait scheduler.
package prws_pkg;

	localparam int ID_W   = 8;
	localparam int PRIO_W = 3;
	localparam int TIME_W = 8;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 3;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	localparam logic OUT_BLOCK  = 1'b0;
	localparam logic OUT_FINISH = 1'b1;

	typedef enum logic [M_TUSER_W-1:0] {
		RES_ADDED    = 3'd0,
		RES_FULL     = 3'd1,
		RES_IDLE     = 3'd2,
		RES_BLOCKED  = 3'd3,
		RES_FINISHED = 3'd4,
		RES_RENEWED  = 3'd5
	} result_t;

	// Per-slot task record kept in the slot memory.
	typedef struct packed {
		logic [TIME_W-1:0] remaining;
		logic [PRIO_W-1:0] prio;
		logic [ID_W-1:0]   ident;
	} slot_rec_t;

endpackage

// ===== rtl/prws_ram.sv =====
// Simple dual-port synchronous RAM with one write port and one registered read port.
module prws_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/priority_ready_wait_scheduler.sv =====
// Top level of the ready/wait multilevel priority queue scheduler.
// An add word, or a run word that finds both sets empty, is finished in IDLE; a run word
// that finds a task also needs EXEC, during which no word is taken, set by the registered read of the slot memory
// followed by the write-back of the record, its link and the queue pointers.
// The result word is registered: an add or an empty run loads it when it is accepted,
// and a run that finds a task loads it from EXEC.
// Reset (arst_n low, asynchronous): every queue empty, every slot free; no clearing pass.
module priority_ready_wait_scheduler
	import prws_pkg::*;
#(
	parameter int PRIO_LEVELS = 6,
	parameter int TASK_SLOTS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// task_id[7:0], task_prio[10:8], task_time[18:11], run_outcome[19],
	// renew_prio[22:20], renew_time[30:23], zero fill[31]
	input  logic [S_TDATA_W-1:0] s_tdata,
	// operation
	input  logic                 s_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// ran_id[7:0], ran_prio[10:8], left_time[18:11], zero fill[23:19]
	output logic [M_TDATA_W-1:0] m_tdata,
	// result_code
	output logic [M_TUSER_W-1:0] m_tuser
);

	localparam int NUM_Q  = 2 * PRIO_LEVELS;
	localparam int Q_W    = $clog2(NUM_Q);
	localparam int SLOT_W = $clog2(TASK_SLOTS);
	localparam int REC_W  = $bits(slot_rec_t);

	// The sequencer has two states: IDLE takes a word and, for a run, launches the slot
	// memory read at the head of the chosen queue; EXEC finishes the run with the record.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	function automatic logic [PRIO_W-1:0] clamp_prio(input logic [PRIO_W-1:0] p);
		if (int'(p) >= PRIO_LEVELS) begin
			clamp_prio = PRIO_W'(PRIO_LEVELS - 1);
		end else begin
			clamp_prio = p;
		end
	endfunction

	state_t state_q;

	// Queue table. Index is set * PRIO_LEVELS + priority, ready set first. Heads and
	// tails are only looked at for occupied queues, so they carry no reset.
	logic [NUM_Q-1:0]      occ_q;
	logic [SLOT_W-1:0]     first_q [NUM_Q];
	logic [SLOT_W-1:0]     last_q  [NUM_Q];
	logic [TASK_SLOTS-1:0] free_q;

	// Run context carried from the accepting cycle into EXEC.
	logic [SLOT_W-1:0] slot_s1;
	logic [Q_W-1:0]    qd_s1;
	logic              one_s1;
	logic              outcome_s1;
	logic [PRIO_W-1:0] np_s1;
	logic [TIME_W-1:0] renew_time_s1;

	// Output register.
	logic              m_tvalid_q;
	result_t           res_q;
	logic [ID_W-1:0]   ran_id_q;
	logic [PRIO_W-1:0] ran_prio_q;
	logic [TIME_W-1:0] left_q;

	// Input word fields.
	logic              in_op;
	logic [ID_W-1:0]   in_id;
	logic [PRIO_W-1:0] in_prio;
	logic [TIME_W-1:0] in_time;
	logic              in_outcome;
	logic [PRIO_W-1:0] in_rprio;
	logic [TIME_W-1:0] in_rtime;

	logic take;
	logic take_add;
	logic take_run;

	// Searches over the occupied and free bits.
	logic              rdy_hit;
	logic              wait_hit;
	logic [Q_W-1:0]    rdy_q;
	logic [Q_W-1:0]    wait_q;
	logic [Q_W-1:0]    qd;
	logic              any_task;
	logic              free_hit;
	logic [SLOT_W-1:0] free_slot;
	logic [PRIO_W-1:0] add_prio;
	logic [Q_W-1:0]    qa;

	// Single read port on the queue table.
	logic [Q_W-1:0]    rq;
	logic [SLOT_W-1:0] rq_first;
	logic [SLOT_W-1:0] rq_last;
	logic              rq_occ;

	// EXEC datapath.
	slot_rec_t         rec_rd;
	logic [REC_W-1:0]  rec_rd_raw;
	logic [SLOT_W-1:0] link_rd;
	logic              ex_renew;
	logic [TIME_W-1:0] ex_rem;
	logic [PRIO_W-1:0] ex_prio;
	logic              ex_enq;
	logic [Q_W-1:0]    qe;
	result_t           ex_res;

	// Memory ports.
	logic              rec_we;
	logic [SLOT_W-1:0] rec_waddr;
	slot_rec_t         rec_wdata;
	logic              link_we;
	logic [SLOT_W-1:0] link_waddr;
	logic [SLOT_W-1:0] link_wdata;

	logic st_idle;
	logic st_exec;
	logic out_load;

	assign st_idle = (state_q == ST_IDLE);
	assign st_exec = (state_q == ST_EXEC);

	assign in_op      = s_tuser;
	assign in_id      = s_tdata[7:0];
	assign in_prio    = s_tdata[10:8];
	assign in_time    = s_tdata[18:11];
	assign in_outcome = s_tdata[19];
	assign in_rprio   = s_tdata[22:20];
	assign in_rtime   = s_tdata[30:23];

	// A new word is taken in IDLE once the result register is empty or draining this cycle,
	// so every result can be written into it without a stall.
	assign s_tready = st_idle && (!m_tvalid_q || m_tready);
	assign take     = s_tvalid && s_tready;
	assign take_add = take && (in_op == OP_ADD);
	assign take_run = take && (in_op == OP_RUN);

	// Best occupied queue: the lowest ready priority wins; with the ready set empty the
	// head of the best wait queue runs directly, since moving it to an empty ready set
	// and popping it again leaves the same state.
	always_comb begin
		rdy_hit  = 1'b0;
		wait_hit = 1'b0;
		rdy_q    = '0;
		wait_q   = '0;
		for (int p = PRIO_LEVELS - 1; p >= 0; p--) begin
			if (occ_q[p]) begin
				rdy_hit = 1'b1;
				rdy_q   = Q_W'(p);
			end
			if (occ_q[PRIO_LEVELS + p]) begin
				wait_hit = 1'b1;
				wait_q   = Q_W'(PRIO_LEVELS + p);
			end
		end
	end

	assign qd       = rdy_hit ? rdy_q : wait_q;
	assign any_task = rdy_hit || wait_hit;

	// Lowest-numbered free slot for an add.
	always_comb begin
		free_hit  = 1'b0;
		free_slot = '0;
		for (int s = TASK_SLOTS - 1; s >= 0; s--) begin
			if (free_q[s]) begin
				free_hit  = 1'b1;
				free_slot = SLOT_W'(s);
			end
		end
	end

	assign add_prio = clamp_prio(in_prio);
	assign qa       = Q_W'(add_prio);

	// EXEC: the record and link of the popped slot arrive from the memories.
	assign rec_rd   = slot_rec_t'(rec_rd_raw);
	assign ex_renew = (rec_rd.remaining == '0);
	assign ex_rem   = ex_renew ? renew_time_s1 : rec_rd.remaining - TIME_W'(1);
	assign ex_prio  = ex_renew ? np_s1 : rec_rd.prio;
	assign ex_enq   = ex_renew || (outcome_s1 == OUT_BLOCK);
	assign qe       = Q_W'(PRIO_LEVELS) + Q_W'(ex_prio);

	always_comb begin
		if (ex_renew) begin
			ex_res = RES_RENEWED;
		end else if (outcome_s1 == OUT_BLOCK) begin
			ex_res = RES_BLOCKED;
		end else begin
			ex_res = RES_FINISHED;
		end
	end

	// The queue table is read at one address a cycle: the enqueue target in EXEC, the
	// add target or the dequeue source while taking a word.
	always_comb begin
		if (st_exec) begin
			rq = qe;
		end else if (in_op == OP_ADD) begin
			rq = qa;
		end else begin
			rq = qd;
		end
	end

	assign rq_first = first_q[rq];
	assign rq_last  = last_q[rq];
	assign rq_occ   = occ_q[rq];

	// Record writes: a new task on add, the updated record at the end of a run.
	always_comb begin
		rec_we    = 1'b0;
		rec_waddr = slot_s1;
		rec_wdata = '{remaining: ex_rem, prio: ex_prio, ident: rec_rd.ident};
		if (st_exec) begin
			rec_we = 1'b1;
		end else if (take_add && free_hit) begin
			rec_we    = 1'b1;
			rec_waddr = free_slot;
			rec_wdata = '{remaining: in_time, prio: add_prio, ident: in_id};
		end
	end

	// Link writes: appending behind an existing tail points that tail at the new slot.
	always_comb begin
		link_we    = 1'b0;
		link_waddr = rq_last;
		link_wdata = slot_s1;
		if (st_exec) begin
			link_we = ex_enq && rq_occ;
		end else if (take_add && free_hit) begin
			link_we    = rq_occ;
			link_wdata = free_slot;
		end
	end

	prws_ram #(
		.WIDTH (REC_W),
		.DEPTH (TASK_SLOTS)
	) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (rec_waddr),
		.wdata (REC_W'(rec_wdata)),
		.re    (take_run),
		.raddr (rq_first),
		.rdata (rec_rd_raw)
	);

	prws_ram #(
		.WIDTH (SLOT_W),
		.DEPTH (TASK_SLOTS)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (take_run),
		.raddr (rq_first),
		.rdata (link_rd)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (take_run && any_task) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Occupied and free bits. A queue whose head equals its tail empties when popped,
	// which happens already while taking the word so that EXEC sees it when it
	// appends to the same queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			free_q <= '1;
		end else begin
			if (take_add && free_hit) begin
				free_q[free_slot] <= 1'b0;
				occ_q[qa]         <= 1'b1;
			end
			if (take_run && any_task && (rq_first == rq_last)) begin
				occ_q[qd] <= 1'b0;
			end
			if (st_exec) begin
				if (ex_enq) begin
					occ_q[qe] <= 1'b1;
				end else begin
					free_q[slot_s1] <= 1'b1;
				end
			end
		end
	end

	// Heads and tails.
	always_ff @(posedge clk) begin
		if (take_add && free_hit) begin
			if (!rq_occ) begin
				first_q[qa] <= free_slot;
			end
			last_q[qa] <= free_slot;
		end
		if (st_exec) begin
			// Advance the head of the popped queue past the slot that ran.
			if (!one_s1) begin
				first_q[qd_s1] <= link_rd;
			end
			if (ex_enq) begin
				if (!rq_occ) begin
					first_q[qe] <= slot_s1;
				end
				last_q[qe] <= slot_s1;
			end
		end
	end

	// Run context.
	always_ff @(posedge clk) begin
		if (take_run) begin
			slot_s1       <= rq_first;
			qd_s1         <= qd;
			one_s1        <= (rq_first == rq_last);
			outcome_s1    <= in_outcome;
			np_s1         <= clamp_prio(in_rprio);
			renew_time_s1 <= in_rtime;
		end
	end

	// Result register. Add words and empty runs answer at once; a run that found a task
	// answers from EXEC.
	assign out_load = st_exec || take_add || (take_run && !any_task);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_exec) begin
			res_q      <= ex_res;
			ran_id_q   <= rec_rd.ident;
			ran_prio_q <= rec_rd.prio;
			left_q     <= ex_rem;
		end else if (out_load) begin
			if (take_add) begin
				res_q <= free_hit ? RES_ADDED : RES_FULL;
			end else begin
				res_q <= RES_IDLE;
			end
			ran_id_q   <= '0;
			ran_prio_q <= '0;
			left_q     <= '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = M_TUSER_W'(res_q);
	assign m_tdata  = {(M_TDATA_W - ID_W - PRIO_W - TIME_W)'(0), left_q, ran_prio_q, ran_id_q};

endmodule

// ===== test/prws_checker.sv =====
// Scoreboard for the ready/wait scheduler: predicts each result word and compares it.
module prws_checker
	import prws_pkg::*;
#(
	parameter int PRIO_LEVELS = 6,
	parameter int TASK_SLOTS  = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	// task_id, task_prio, task_time, run_outcome, renew_prio, renew_time, zero fill
	input  logic [S_TDATA_W-1:0] s_tdata,
	// operation
	input  logic                 s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	// ran_id, ran_prio, left_time, zero fill
	input  logic [M_TDATA_W-1:0] m_tdata,
	// result_code
	input  logic [M_TUSER_W-1:0] m_tuser,
	output int                   mismatches,
	output int                   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOT_W     = $clog2(TASK_SLOTS);
	localparam int NUM_QUEUES = 2 * PRIO_LEVELS;
	localparam int SET_READY  = 0;
	localparam int SET_WAIT   = 1;
	localparam int REPORT_MAX = 10;

	typedef struct packed {
		result_t           code;
		logic [ID_W-1:0]   ident;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] left;
	} sched_result_t;

	// Model copy of the task table and the linked queues.
	logic [ID_W-1:0]   task_ident [TASK_SLOTS];
	logic [PRIO_W-1:0] task_prio  [TASK_SLOTS];
	logic [TIME_W-1:0] task_left  [TASK_SLOTS];
	logic [SLOT_W-1:0] task_link  [TASK_SLOTS];
	logic [SLOT_W-1:0] queue_head [NUM_QUEUES];
	logic [SLOT_W-1:0] queue_tail [NUM_QUEUES];
	logic              queue_busy [NUM_QUEUES];
	logic [TASK_SLOTS-1:0] slot_free;

	sched_result_t expected_results[$];
	int bad_words;

	function automatic logic [PRIO_W-1:0] clamp_level(input logic [PRIO_W-1:0] p);
		return (p >= PRIO_LEVELS) ? PRIO_W'(PRIO_LEVELS - 1) : p;
	endfunction

	function automatic void push_task(input int set, input int lvl, input int s);
		int q;
		q = set * PRIO_LEVELS + lvl;
		task_link[s] = '0;
		if (queue_busy[q])
			task_link[queue_tail[q]] = SLOT_W'(s);
		else
			queue_head[q] = SLOT_W'(s);
		queue_tail[q] = SLOT_W'(s);
		queue_busy[q] = 1'b1;
	endfunction

	function automatic int pop_task(input int set, input int lvl);
		int q;
		int s;
		q = set * PRIO_LEVELS + lvl;
		s = queue_head[q];
		if (queue_head[q] == queue_tail[q])
			queue_busy[q] = 1'b0;
		else
			queue_head[q] = task_link[s];
		return s;
	endfunction

	// Best (lowest numbered) occupied level of a set, -1 when the set is empty.
	function automatic int best_level(input int set);
		int lvl;
		lvl = -1;
		for (int p = PRIO_LEVELS - 1; p >= 0; p--)
			if (queue_busy[set * PRIO_LEVELS + p])
				lvl = p;
		return lvl;
	endfunction

	function automatic sched_result_t schedule_word(input logic op,
			input logic [S_TDATA_W-1:0] d);
		sched_result_t r;
		int rl;
		int wl;
		int s;
		logic placed;
		logic [PRIO_W-1:0] np;
		r = '0;
		placed = 1'b0;
		if (op == OP_ADD) begin
			r.code = RES_FULL;
			for (int i = 0; i < TASK_SLOTS; i++) begin
				if (!placed && slot_free[i]) begin
					placed = 1'b1;
					slot_free[i] = 1'b0;
					task_ident[i] = d[7:0];
					task_prio[i] = clamp_level(d[10:8]);
					task_left[i] = d[18:11];
					push_task(SET_READY, task_prio[i], i);
					r.code = RES_ADDED;
				end
			end
		end else begin
			rl = best_level(SET_READY);
			if (rl < 0) begin
				wl = best_level(SET_WAIT);
				if (wl >= 0) begin
					s = pop_task(SET_WAIT, wl);
					push_task(SET_READY, task_prio[s], s);
					rl = best_level(SET_READY);
				end
			end
			if (rl < 0) begin
				r.code = RES_IDLE;
			end else begin
				s = pop_task(SET_READY, rl);
				r.ident = task_ident[s];
				r.prio = task_prio[s];
				if (task_left[s] == '0) begin
					np = clamp_level(d[22:20]);
					task_prio[s] = np;
					task_left[s] = d[30:23];
					push_task(SET_WAIT, np, s);
					r.left = d[30:23];
					r.code = RES_RENEWED;
				end else begin
					task_left[s] = task_left[s] - 1'b1;
					r.left = task_left[s];
					if (d[19] == OUT_BLOCK) begin
						push_task(SET_WAIT, task_prio[s], s);
						r.code = RES_BLOCKED;
					end else begin
						slot_free[s] = 1'b1;
						r.code = RES_FINISHED;
					end
				end
			end
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t want;
		if (!arst_n) begin
			for (int q = 0; q < NUM_QUEUES; q++)
				queue_busy[q] = 1'b0;
			slot_free = '1;
			expected_results.delete();
			bad_words = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					if (bad_words < REPORT_MAX)
						$display("%0t: unexpected result word code %0d data %h",
							$realtime, m_tuser, m_tdata);
					bad_words++;
				end else begin
					want = expected_results.pop_front();
					if (m_tuser != want.code || m_tdata[7:0] != want.ident ||
							m_tdata[10:8] != want.prio || m_tdata[18:11] != want.left ||
							m_tdata[23:19] != '0) begin
						if (bad_words < REPORT_MAX)
							$display({"%0t: result mismatch, expected code %0d id %h prio %0d ",
								"left %h, got code %0d id %h prio %0d left %h fill %h"},
								$realtime, want.code, want.ident, want.prio, want.left,
								m_tuser, m_tdata[7:0], m_tdata[10:8], m_tdata[18:11],
								m_tdata[23:19]);
						bad_words++;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_results.push_back(schedule_word(s_tuser, s_tdata));
			mismatches <= bad_words;
			outstanding <= expected_results.size();
		end
	end

endmodule

// ===== test/priority_ready_wait_scheduler_tb.sv =====
// Testbench top for the ready/wait scheduler: clock, reset, stimulus and the verdict.
module priority_ready_wait_scheduler_tb
	import prws_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PRIO_LEVELS    = 6;
	localparam int TASK_SLOTS     = 16;
	localparam int RESET_CYCLES   = 7;
	localparam int PHASE_WORDS    = 225;
	// Length of the long receiver hold-off that backs the block up.
	localparam int HOLD_CYCLES    = 300;
	// Cycles without any accepted word before the run is declared hung. The
	// longest legal quiet stretch is the hold-off above; random gaps are short.
	localparam int WATCHDOG_LIMIT = 4000;
	// Settling time once every result has arrived; the result of a run word that
	// finds a task comes from EXEC after the registered read of the slot memory.
	localparam int TAIL_CYCLES    = 8;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata = '0;
	logic                 s_tuser = OP_ADD;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [M_TUSER_W-1:0] m_tuser;

	int mismatches;
	int outstanding;

	// Idle shares in percent for the sender and the receiver.
	int   src_idle_pct = 0;
	int   snk_stall_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int   hold_left = 0;
	int   quiet_cycles = 0;

	always #2 clk = ~clk;

	priority_ready_wait_scheduler #(
		.PRIO_LEVELS(PRIO_LEVELS),
		.TASK_SLOTS (TASK_SLOTS)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	prws_checker #(
		.PRIO_LEVELS(PRIO_LEVELS),
		.TASK_SLOTS (TASK_SLOTS)
	) checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.mismatches (mismatches),
		.outstanding(outstanding)
	);

	// Receiver side. A single long hold-off is taken once it is requested;
	// otherwise ready drops at random according to the current stall share.
	always @(posedge clk) begin
		if (hold_req && !hold_done) begin
			hold_done = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Watchdog: counts cycles in which neither channel moves a word.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Builds an input word, first field in the lowest bits.
	function automatic logic [S_TDATA_W-1:0] pack_word(input logic [ID_W-1:0] id,
			input logic [PRIO_W-1:0] pr, input logic [TIME_W-1:0] tm, input logic oc,
			input logic [PRIO_W-1:0] rp, input logic [TIME_W-1:0] rt);
		return {1'b0, rt, rp, oc, tm, pr, id};
	endfunction

	// Offers one word and returns at the edge where it is taken. An optional
	// random gap comes first; valid only drops when such a gap is inserted,
	// so back-to-back words keep it high without a glitch.
	task automatic put_word(input logic op, input logic [S_TDATA_W-1:0] data);
		int gap;
		gap = 0;
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= data;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Mostly short times so tasks renew, block and finish often; now and
	// then the full range.
	function automatic logic [TIME_W-1:0] pick_time();
		return ($urandom_range(3) == 0) ? TIME_W'($urandom_range(255)) :
			TIME_W'($urandom_range(3));
	endfunction

	initial begin
		int add_pct;
		int src_pct[4];
		int snk_pct[4];
		logic op;
		src_pct = '{0, 53, 0, 6};
		snk_pct = '{0, 0, 53, 6};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. A run with nothing queued comes first.
		put_word(OP_RUN, pack_word(8'hA5, 3'd2, 8'h10, OUT_FINISH, 3'd1, 8'h20));
		// An out-of-range priority saturates to the highest-numbered level; zero time.
		put_word(OP_ADD, pack_word(8'hFF, 3'd7, 8'h00, OUT_FINISH, 3'd7, 8'hFF));
		put_word(OP_ADD, pack_word(8'h00, 3'd0, 8'hFF, OUT_BLOCK, 3'd0, 8'h00));
		put_word(OP_ADD, pack_word(8'h55, 3'd3, 8'h01, OUT_BLOCK, 3'd4, 8'h7F));
		// Best ready task blocks and goes to the wait set with its time decremented.
		put_word(OP_RUN, pack_word(8'h12, 3'd5, 8'h34, OUT_BLOCK, 3'd6, 8'h56));
		// A task with a single unit left finishes at zero.
		put_word(OP_RUN, pack_word(8'hFF, 3'd7, 8'hFF, OUT_FINISH, 3'd3, 8'h80));
		// A task with no time left is renewed with a saturated priority.
		put_word(OP_RUN, pack_word(8'h00, 3'd0, 8'h00, OUT_FINISH, 3'd7, 8'hFF));
		// Ready set empty: the best waiting task is promoted and runs.
		put_word(OP_RUN, pack_word(8'h81, 3'd1, 8'h02, OUT_FINISH, 3'd0, 8'h01));
		put_word(OP_RUN, pack_word(8'h7E, 3'd6, 8'hFD, OUT_BLOCK, 3'd5, 8'hAA));
		put_word(OP_RUN, pack_word(8'h3C, 3'd4, 8'h40, OUT_FINISH, 3'd2, 8'h55));
		put_word(OP_RUN, pack_word(8'hC3, 3'd1, 8'h08, OUT_BLOCK, 3'd1, 8'h04));
		// Fill every slot, then one add too many.
		for (int i = 0; i < TASK_SLOTS; i++)
			put_word(OP_ADD, pack_word(ID_W'(i == 5 ? 3 : i * 17), PRIO_W'(i % 8),
				(i % 2) ? 8'hFF : 8'h00, i[0], PRIO_W'(7 - i % 8), TIME_W'(i)));
		put_word(OP_ADD, pack_word(8'hEE, 3'd1, 8'h05, OUT_BLOCK, 3'd2, 8'h06));

		// Random part in four idling phases. The add share changes every few
		// dozen words so the table swings between full and empty.
		add_pct = 50;
		for (int ph = 0; ph < 4; ph++) begin
			src_idle_pct = src_pct[ph];
			snk_stall_pct <= snk_pct[ph];
			for (int i = 0; i < PHASE_WORDS; i++) begin
				if (i % 50 == 0)
					add_pct = $urandom_range(85, 15);
				// Hold the receiver off while the sender keeps offering words.
				if (ph == 0 && i == 100)
					hold_req <= 1'b1;
				op = ($urandom_range(99) < add_pct) ? OP_ADD : OP_RUN;
				put_word(op, pack_word(ID_W'($urandom_range(255)),
					PRIO_W'($urandom_range(7)), pick_time(), 1'($urandom_range(1)),
					PRIO_W'($urandom_range(7)), pick_time()));
			end
		end
		s_tvalid <= 1'b0;

		// Drain: wait for every expected result, then let the block settle.
		while (outstanding != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/prws_pkg.sv
rtl/prws_ram.sv
rtl/priority_ready_wait_scheduler.sv
test/prws_checker.sv
test/priority_ready_wait_scheduler_tb.sv
